### hw/rtl/lcs_pkg.sv
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned ProdW    = 2 * PixW;
  localparam int unsigned StepCntW = $clog2(PixW);

  localparam logic [PixW-1:0]     FullScale = '1;
  localparam logic [StepCntW-1:0] LastStep  = StepCntW'(PixW - 1);

  localparam logic [PixW-1:0] LowReset  = '1;
  localparam logic [PixW-1:0] HighReset = '0;

  localparam logic OpGather  = 1'b0;
  localparam logic OpStretch = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  typedef struct packed {
    logic gather;
    logic start;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/lcs_ctrl.sv
`timescale 1ns / 1ps

module lcs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          op,
  output logic          in_stall,
  input  lcs_pkg::sts_t sts,
  output lcs_pkg::cmd_t cmd
);

  lcs_pkg::state_t state;
  lcs_pkg::state_t state_next;

  logic idle;

  assign idle     = (state == lcs_pkg::S_IDLE);
  assign in_stall = !idle;

  always_comb begin
    cmd.gather = idle && in_valid && (op == lcs_pkg::OpGather);
    cmd.start  = idle && in_valid && (op == lcs_pkg::OpStretch);
    cmd.step   = (state == lcs_pkg::S_DIV);
    cmd.load   = (state == lcs_pkg::S_OUT) && !sts.out_busy;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lcs_pkg::S_IDLE: begin
        if (cmd.start) state_next = lcs_pkg::S_DIV;
      end
      lcs_pkg::S_DIV: begin
        if (sts.last_step) state_next = lcs_pkg::S_OUT;
      end
      lcs_pkg::S_OUT: begin
        if (!sts.out_busy) state_next = lcs_pkg::S_IDLE;
      end
      default: state_next = lcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == lcs_pkg::S_DIV)
    else $error("stretch transfer did not start the divider");

  a_div_runs_out: assert property (@(posedge clk) disable iff (rst)
    (state == lcs_pkg::S_DIV && !sts.last_step) |=> state == lcs_pkg::S_DIV)
    else $error("divider left before its last step");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == lcs_pkg::S_OUT && sts.out_busy) |=> state == lcs_pkg::S_OUT)
    else $error("result dropped while output register busy");

endmodule

### hw/rtl/lcs_datapath.sv
`timescale 1ns / 1ps

module lcs_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  lcs_pkg::cmd_t             cmd,
  output lcs_pkg::sts_t             sts,
  input  logic [lcs_pkg::PixW-1:0]  pixel,
  input  logic                      frame_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lcs_pkg::PixW-1:0]  stretched
);

  logic [lcs_pkg::PixW-1:0]     low_seen;
  logic [lcs_pkg::PixW-1:0]     high_seen;
  logic [lcs_pkg::PixW-1:0]     rem;
  logic [lcs_pkg::PixW-1:0]     dsh;
  logic [lcs_pkg::PixW-1:0]     divisor;
  logic [lcs_pkg::PixW-1:0]     quo;
  logic [lcs_pkg::StepCntW-1:0] cnt;
  logic                         spec;
  logic [lcs_pkg::PixW-1:0]     spec_val;

  logic [lcs_pkg::PixW-1:0]  diff;
  logic [lcs_pkg::ProdW-1:0] num;
  logic [lcs_pkg::PixW:0]    trial;
  logic                      fits;

  // (p - lo) * 255 as a shift and subtract
  assign diff  = pixel - low_seen;
  assign num   = {diff, lcs_pkg::PixW'(0)} - {lcs_pkg::PixW'(0), diff};
  assign trial = {rem, dsh[lcs_pkg::PixW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  assign sts.last_step = (cnt == lcs_pkg::LastStep);
  assign sts.out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_seen  <= lcs_pkg::LowReset;
      high_seen <= lcs_pkg::HighReset;
    end else if (cmd.gather) begin
      if (frame_start) begin
        low_seen  <= pixel;
        high_seen <= pixel;
      end else begin
        if (pixel < low_seen) low_seen <= pixel;
        if (pixel > high_seen) high_seen <= pixel;
      end
    end
  end

  // restoring divider, one quotient bit a cycle; quotient fits 8 bits for pixels strictly between min and max
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem      <= num[lcs_pkg::ProdW-1:lcs_pkg::PixW];
      dsh      <= num[lcs_pkg::PixW-1:0];
      divisor  <= high_seen - low_seen;
      quo      <= '0;
      cnt      <= '0;
      spec     <= (high_seen <= low_seen) || (pixel <= low_seen) || (pixel >= high_seen);
      spec_val <= ((high_seen > low_seen) && (pixel >= high_seen)) ? lcs_pkg::FullScale : '0;
    end else if (cmd.step) begin
      rem <= fits ? lcs_pkg::PixW'(trial - {1'b0, divisor}) : trial[lcs_pkg::PixW-1:0];
      dsh <= {dsh[lcs_pkg::PixW-2:0], 1'b0};
      quo <= {quo[lcs_pkg::PixW-2:0], fits};
      cnt <= cnt + lcs_pkg::StepCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stretched <= '0;
    end else if (cmd.load) begin
      stretched <= spec ? spec_val : quo;
    end
  end

  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    cmd.gather |=> low_seen <= high_seen)
    else $error("low bound above high bound after gather");

  a_quotient_below_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !spec) |=> stretched != lcs_pkg::FullScale)
    else $error("in-range pixel reached full scale");

  a_gather_keeps_output: assert property (@(posedge clk) disable iff (rst)
    cmd.gather |=> $stable(stretched))
    else $error("gather transfer disturbed the output register");

endmodule

### hw/rtl/linear_contrast_stretch_core.sv
`timescale 1ns / 1ps

// min/max contrast stretch for 8-bit grey frames
// input channel: in_valid/in_stall with op, pixel, frame_start
//   op low: gather pixel, updates the running min and max (frame_start restarts them)
//   op high: stretch pixel, gives one result on the output channel
// output channel: out_valid/out_stall with stretched
// a gather pixel does not stall the input and gives no transfer on the output side
// a stretch pixel loads the divider at its transfer, then holds the input while
//   the restoring divider finds eight quotient bits (one quotient bit a cycle)
//   and until the result is loaded into the output register, which raises out_valid
// a flat range and pixels at or below min give 0; other pixels at or above max give 255
// while the receiver stalls, the result waits in the output register and the
//   input keeps taking gather pixels; a stretch pixel finishes its division
//   and then waits until the output register is free
// reset sets min to 255, max to 0 and empties the output register
module linear_contrast_stretch_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic [lcs_pkg::PixW-1:0] pixel,
  input  logic                     frame_start,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [lcs_pkg::PixW-1:0] stretched
);

  lcs_pkg::cmd_t cmd;
  lcs_pkg::sts_t sts;

  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stretched   (stretched)
  );

endmodule
